@@ design/dqp_pkg.sv @@
// shared types and constants for the dns question parser
// no dependencies
package dqp_pkg;
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BADLEN    = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_POOLFULL  = 2'd3;
  localparam int unsigned HDR_BYTES   = 12;
  localparam int unsigned MAX_NAME    = 255;
endpackage

@@ design/dns_question_parser.sv @@
// dns question parser top level: message store, label pool, parse sequencer
// depends on dqp_pkg
//
// usage: while in_stall is low the in_ channel loads one message word (byte) per
// cycle into the message store; in_last_byte marks the final word of the message.
// after the final word the block walks the header and first question out of
// the store, one store read per cycle, and emits the dotted name in 8-byte
// out_ words followed by one summary word with out_last set.
// loading runs at one word per cycle while in_stall is low. the parse walks the
// header, then the labels, then scans the pool on a pointer, then builds the
// name, then reads qtype and qclass, and then gathers the out_ words from the
// name store; the header, label, build and qtype/qclass steps share the single
// store read port.
// in_stall stays high from the final word until the summary word is loaded
// into the out_ register.
// out_ holds its word while out_stall is high; the sequencer waits.
// reset clears the control state only; the stores need no clearing.
module dns_question_parser #(
  parameter int unsigned MAX_MSG_BYTES    = 4096,
  parameter int unsigned LABEL_POOL_DEPTH = 127
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_name_chunk,
  output logic [3:0]  out_chunk_bytes,
  output logic [1:0]  out_status,
  output logic [15:0] out_msg_id,
  output logic [15:0] out_flag_bits,
  output logic [15:0] out_question_count,
  output logic [15:0] out_answer_count,
  output logic [15:0] out_authority_count,
  output logic [15:0] out_additional_count,
  output logic [15:0] out_query_type,
  output logic [15:0] out_query_class,
  output logic        out_last
);
  localparam int unsigned AW = (MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1;
  localparam int unsigned PW = (LABEL_POOL_DEPTH > 1) ? $clog2(LABEL_POOL_DEPTH) : 1;
  localparam logic [16:0] MAXB = 17'(MAX_MSG_BYTES);
  localparam logic [8:0]  PDEP = 9'(LABEL_POOL_DEPTH);

  typedef enum logic [4:0] {
    S_LOAD, S_HDR, S_CHK, S_CHK_PTR, S_SCAN, S_SCAN_W,
    S_BLD, S_BLD_PTR, S_BLD_TGT, S_BLD_CHR,
    S_Q, S_EMIT, S_SUM
  } state_t;

  logic [7:0]  mem [MAX_MSG_BYTES];
  logic [15:0] pool [LABEL_POOL_DEPTH];
  logic [7:0]  name_mem [256];

  state_t      state_r;
  logic [16:0] cnt_r;
  logic        oversize_r;
  logic [7:0]  rdata_r;
  logic [17:0] raddr_r;
  logic        rpend_r;
  logic [15:0] pdata_r;
  logic [15:0] hdr_r [6];
  logic [3:0]  hidx_r;
  logic [17:0] off_r;
  logic [17:0] start_r;
  logic [8:0]  pcnt_r;
  logic [8:0]  pidx_r;
  logic        found_r;
  logic [15:0] ptgt_r;
  logic [7:0]  b_r;
  logic [7:0]  k_r;
  logic [8:0]  nl_r;
  logic [2:0]  qi_r;
  logic [15:0] qt_r, qc_r;
  logic [1:0]  st_r;
  logic [8:0]  epos_r;
  logic [7:0]  nrd_r;
  logic [3:0]  ebyte_r;
  logic [63:0] chunk_r;
  logic        ov_r;
  logic        oinit_r;

  wire in_acc   = in_valid && !in_stall;
  wire out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != S_LOAD);
  assign out_valid = ov_r;

  // chunk still has name bytes to gather
  wire emit_gather = (ebyte_r != 4'd8) && (epos_r + {5'd0, ebyte_r} < nl_r);
  // a word goes into the out_ register this cycle
  wire out_load = out_free && ((state_r == S_SUM) ||
                               (state_r == S_EMIT && !oinit_r && !emit_gather));

  // read-valid: address inside the message
  wire rok = (raddr_r < {1'b0, cnt_r});

  // store write and registered read
  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && in_acc && cnt_r < MAXB)
      mem[cnt_r[AW-1:0]] <= in_msg_byte;
    rdata_r <= mem[raddr_r[AW-1:0]];
    pdata_r <= pool[pidx_r[PW-1:0]];
    nrd_r   <= name_mem[epos_r[7:0] + {5'd0, ebyte_r[2:0]}];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CHK && rpend_r == 1'b0 && rok && rdata_r != 8'd0 &&
        rdata_r[7:6] != 2'b11 && rdata_r <= 8'd63 && pcnt_r < PDEP)
      pool[pcnt_r[PW-1:0]] <= off_r[15:0];
    if (state_r == S_BLD_CHR && !rpend_r && k_r != b_r)
      name_mem[8'(nl_r + {1'b0, k_r})] <= rdata_r;
    if (state_r == S_BLD_CHR && !rpend_r && k_r == b_r)
      name_mem[8'(nl_r + {1'b0, b_r})] <= 8'h2e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r <= '0;
      oversize_r <= 1'b0;
      ov_r <= 1'b0;
      rpend_r <= 1'b0;
    end else begin
      if (out_load) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (cnt_r < MAXB) cnt_r <= cnt_r + 17'd1;
            else oversize_r <= 1'b1;
            if (in_last_byte) begin
              for (int i = 0; i < 6; i++) hdr_r[i] <= '0;
              qt_r <= '0; qc_r <= '0; nl_r <= '0; pcnt_r <= '0;
              hidx_r <= '0;
              raddr_r <= '0;
              rpend_r <= 1'b1;
              if (oversize_r || (cnt_r + 17'd1) < 17'(dqp_pkg::HDR_BYTES) ||
                  (cnt_r >= MAXB)) begin
                st_r <= dqp_pkg::ST_BADLEN;
                state_r <= S_SUM;
              end else begin
                st_r <= dqp_pkg::ST_OK;
                state_r <= S_HDR;
              end
            end
          end
        end
        S_HDR: begin
          // one header byte per cycle, address leads data by one read register
          if (rpend_r) begin
            rpend_r <= 1'b0;
            raddr_r <= 18'd1;
          end else begin
            hdr_r[hidx_r[3:1]] <= hidx_r[0] ? {hdr_r[hidx_r[3:1]][15:8], rdata_r}
                                             : {rdata_r, 8'd0};
            hidx_r <= hidx_r + 4'd1;
            if (hidx_r == 4'd11) begin
              if (hdr_r[2] == 16'd0) state_r <= S_SUM;
              else begin
                off_r <= 18'd12; start_r <= 18'd12;
                raddr_r <= 18'd12; rpend_r <= 1'b1;
                state_r <= S_CHK;
              end
            end else raddr_r <= raddr_r + 18'd1;
          end
        end
        S_CHK: begin
          if (rpend_r) rpend_r <= 1'b0;
          else if (!rok) begin
            st_r <= dqp_pkg::ST_MALFORMED; state_r <= S_SUM;
          end else if (rdata_r == 8'd0) begin
            off_r <= off_r + 18'd1;
            nl_r <= '0; raddr_r <= start_r; rpend_r <= 1'b1;
            state_r <= S_BLD;
          end else if (rdata_r[7:6] == 2'b11) begin
            b_r <= rdata_r;
            raddr_r <= off_r + 18'd1; rpend_r <= 1'b1;
            state_r <= S_CHK_PTR;
          end else if (rdata_r > 8'd63) begin
            st_r <= dqp_pkg::ST_MALFORMED; state_r <= S_SUM;
          end else if (pcnt_r >= PDEP) begin
            st_r <= dqp_pkg::ST_POOLFULL; state_r <= S_SUM;
          end else begin
            pcnt_r <= pcnt_r + 9'd1;
            off_r <= off_r + {10'd0, rdata_r} + 18'd1;
            raddr_r <= off_r + {10'd0, rdata_r} + 18'd1;
            rpend_r <= 1'b1;
          end
        end
        S_CHK_PTR: begin
          if (rpend_r) rpend_r <= 1'b0;
          else if (!rok) begin
            st_r <= dqp_pkg::ST_MALFORMED; state_r <= S_SUM;
          end else begin
            ptgt_r <= {2'b00, b_r[5:0], rdata_r};
            off_r <= off_r + 18'd2;
            pidx_r <= '0; found_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // pool lookup, one entry per pass through S_SCAN and S_SCAN_W
          if (pidx_r >= pcnt_r) begin
            if (found_r) begin
              nl_r <= '0; raddr_r <= start_r; rpend_r <= 1'b1;
              state_r <= S_BLD;
            end else begin
              st_r <= dqp_pkg::ST_MALFORMED; state_r <= S_SUM;
            end
          end else state_r <= S_SCAN_W;
        end
        S_SCAN_W: begin
          if (pdata_r == ptgt_r) found_r <= 1'b1;
          pidx_r <= pidx_r + 9'd1;
          state_r <= S_SCAN;
        end
        S_BLD: begin
          if (rpend_r) rpend_r <= 1'b0;
          else if (!rok) begin
            st_r <= dqp_pkg::ST_MALFORMED; state_r <= S_SUM;
          end else if (rdata_r == 8'd0) begin
            qi_r <= '0; raddr_r <= off_r; rpend_r <= 1'b1;
            if (off_r + 18'd4 > {1'b0, cnt_r}) begin
              st_r <= dqp_pkg::ST_MALFORMED; state_r <= S_SUM;
            end else state_r <= S_Q;
          end else if (rdata_r[7:6] != 2'b00) begin
            b_r <= rdata_r;
            raddr_r <= start_r + 18'd1; rpend_r <= 1'b1;
            state_r <= S_BLD_PTR;
          end else begin
            b_r <= rdata_r;
            if ({1'b0, nl_r} + {2'b0, rdata_r} + 10'd1 > 10'(dqp_pkg::MAX_NAME)) begin
              st_r <= dqp_pkg::ST_MALFORMED; state_r <= S_SUM;
            end else begin
              k_r <= '0; raddr_r <= start_r + 18'd1; rpend_r <= 1'b1;
              state_r <= S_BLD_CHR;
            end
          end
        end
        S_BLD_PTR: begin
          if (rpend_r) rpend_r <= 1'b0;
          else if (!rok) begin
            st_r <= dqp_pkg::ST_MALFORMED; state_r <= S_SUM;
          end else begin
            start_r <= {4'd0, b_r[5:0], rdata_r};
            raddr_r <= {4'd0, b_r[5:0], rdata_r}; rpend_r <= 1'b1;
            state_r <= S_BLD_TGT;
          end
        end
        S_BLD_TGT: begin
          // target byte is a length whatever its top bits
          if (rpend_r) rpend_r <= 1'b0;
          else if (!rok) begin
            st_r <= dqp_pkg::ST_MALFORMED; state_r <= S_SUM;
          end else begin
            b_r <= rdata_r;
            if ({1'b0, nl_r} + {2'b0, rdata_r} + 10'd1 > 10'(dqp_pkg::MAX_NAME)) begin
              st_r <= dqp_pkg::ST_MALFORMED; state_r <= S_SUM;
            end else begin
              k_r <= '0; raddr_r <= start_r + 18'd1; rpend_r <= (rdata_r != 8'd0);
              state_r <= S_BLD_CHR;
            end
          end
        end
        S_BLD_CHR: begin
          if (rpend_r) rpend_r <= 1'b0;
          else if (k_r == b_r) begin
            start_r <= start_r + {10'd0, b_r} + 18'd1;
            raddr_r <= start_r + {10'd0, b_r} + 18'd1; rpend_r <= 1'b1;
            nl_r <= nl_r + {1'b0, b_r} + 9'd1;
            state_r <= S_BLD;
          end else if (!rok) begin
            st_r <= dqp_pkg::ST_MALFORMED; state_r <= S_SUM;
          end else begin
            k_r <= k_r + 8'd1;
            raddr_r <= raddr_r + 18'd1;
            rpend_r <= (k_r + 8'd1 != b_r);
          end
        end
        S_Q: begin
          if (rpend_r) begin
            rpend_r <= 1'b0; raddr_r <= raddr_r + 18'd1;
          end else begin
            unique case (qi_r[1:0])
              2'd0: qt_r[15:8] <= rdata_r;
              2'd1: qt_r[7:0]  <= rdata_r;
              2'd2: qc_r[15:8] <= rdata_r;
              default: qc_r[7:0] <= rdata_r;
            endcase
            raddr_r <= raddr_r + 18'd1;
            qi_r <= qi_r + 3'd1;
            if (qi_r == 3'd3) begin
              epos_r <= '0; ebyte_r <= '0; oinit_r <= 1'b1;
              chunk_r <= '0;
              state_r <= (nl_r == 9'd0) ? S_SUM : S_EMIT;
            end
          end
        end
        S_EMIT: begin
          // gather the name bytes one at a time, name read lags by one register
          if (oinit_r) oinit_r <= 1'b0;
          else begin
            if (emit_gather) begin
              chunk_r[ebyte_r[2:0]*8 +: 8] <= nrd_r;
              ebyte_r <= ebyte_r + 4'd1;
              oinit_r <= 1'b1;
            end else if (out_free) begin
              out_name_chunk <= chunk_r;
              out_chunk_bytes <= ebyte_r;
              out_status <= dqp_pkg::ST_OK;
              out_msg_id <= '0; out_flag_bits <= '0; out_question_count <= '0;
              out_answer_count <= '0; out_authority_count <= '0;
              out_additional_count <= '0; out_query_type <= '0;
              out_query_class <= '0; out_last <= 1'b0;
              chunk_r <= '0; ebyte_r <= '0; oinit_r <= 1'b1;
              epos_r <= epos_r + {5'd0, ebyte_r};
              if (epos_r + {5'd0, ebyte_r} >= nl_r) state_r <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (out_free) begin
            out_name_chunk <= '0; out_chunk_bytes <= '0;
            out_status <= st_r;
            out_msg_id <= hdr_r[0]; out_flag_bits <= hdr_r[1];
            out_question_count <= hdr_r[2]; out_answer_count <= hdr_r[3];
            out_authority_count <= hdr_r[4]; out_additional_count <= hdr_r[5];
            out_query_type  <= (st_r == dqp_pkg::ST_OK) ? qt_r : 16'd0;
            out_query_class <= (st_r == dqp_pkg::ST_OK) ? qc_r : 16'd0;
            out_last <= 1'b1;
            cnt_r <= '0; oversize_r <= 1'b0;
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

@@ sim/tb.sv @@
// testbench for dns_question_parser: drives dns messages a byte per word and
// checks name chunks and the summary word against a behavioral predictor
// depends on dqp_pkg and design/dns_question_parser.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MSG_MAX   = 4096;
  localparam int POOL_MAX  = 127;
  localparam int CYCLE_CAP = 3000000;

  typedef struct packed {
    logic [63:0] chunk;
    logic [3:0]  nbytes;
    logic [1:0]  status;
    logic [15:0] id, flags, qdc, anc, nsc, arc, qtype, qclass;
    logic        last;
  } rec_t;

  logic        clk = 1'b0, rst_n = 1'b0;
  logic        in_valid = 1'b0, in_stall;
  logic [7:0]  in_msg_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid, out_stall = 1'b1;
  logic [63:0] out_name_chunk;
  logic [3:0]  out_chunk_bytes;
  logic [1:0]  out_status;
  logic [15:0] out_msg_id, out_flag_bits, out_question_count, out_answer_count;
  logic [15:0] out_authority_count, out_additional_count, out_query_type,
               out_query_class;
  logic        out_last;

  dns_question_parser u_top (.*);

  initial forever #6 clk = ~clk;

  // predictor state
  logic [7:0] msg_mem[MSG_MAX];
  int         msg_len;
  bit         msg_over;
  rec_t       expected_q[$];
  int         errors = 0;
  longint     cycles = 0;
  bit         idle_on = 1'b1;
  bit         hold_out = 1'b0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic bit rd(input int idx, output int v);
    if (idx >= msg_len || idx >= MSG_MAX) return 0;
    v = msg_mem[idx];
    return 1;
  endfunction

  // parse the stored message and queue the chunks and summary it yields
  task automatic predict_message();
    rec_t r;
    logic [1:0] st;
    logic [15:0] hd[6];
    logic [15:0] qt, qc;
    int pool[POOL_MAX];
    int npool, off, start, b, b2, lp, nl, c, pos, n;
    bit found;
    byte unsigned nm[256];
    st = dqp_pkg::ST_OK; qt = 0; qc = 0; nl = 0; npool = 0;
    foreach (hd[k]) hd[k] = 0;
    if (msg_over || msg_len < 12) st = dqp_pkg::ST_BADLEN;
    else begin
      for (int k = 0; k < 6; k++) hd[k] = {msg_mem[2*k], msg_mem[2*k+1]};
      if (hd[2] != 0) begin
        off = 12; start = 12;
        forever begin
          if (!rd(off, b)) begin st = dqp_pkg::ST_MALFORMED; break; end
          if (b == 0) begin off++; break; end
          if ((b & 8'hc0) == 8'hc0) begin
            if (!rd(off + 1, b2)) begin st = dqp_pkg::ST_MALFORMED; break; end
            lp = ((b & 8'h3f) << 8) | b2;
            off += 2;
            found = 0;
            for (int j = 0; j < npool; j++) if (pool[j] == lp) found = 1;
            if (!found) st = dqp_pkg::ST_MALFORMED;
            break;
          end
          if (b > 63) begin st = dqp_pkg::ST_MALFORMED; break; end
          if (npool >= POOL_MAX) begin st = dqp_pkg::ST_POOLFULL; break; end
          pool[npool++] = off;
          off += b + 1;
        end
        if (st == dqp_pkg::ST_OK) forever begin
          if (!rd(start, b)) begin st = dqp_pkg::ST_MALFORMED; break; end
          if (b == 0) break;
          if (b & 8'hc0) begin
            if (!rd(start + 1, b2)) begin st = dqp_pkg::ST_MALFORMED; break; end
            start = ((b & 8'h3f) << 8) | b2;
            if (!rd(start, b)) begin st = dqp_pkg::ST_MALFORMED; break; end
          end
          if (nl + b + 1 > 255) begin st = dqp_pkg::ST_MALFORMED; break; end
          for (int k = 0; k < b; k++) begin
            if (!rd(start + 1 + k, c)) begin st = dqp_pkg::ST_MALFORMED; break; end
            nm[nl + k] = c;
          end
          if (st != dqp_pkg::ST_OK) break;
          nm[nl + b] = 8'h2e;
          start += b + 1;
          nl += b + 1;
        end
        if (st == dqp_pkg::ST_OK && off + 4 > msg_len) st = dqp_pkg::ST_MALFORMED;
        if (st == dqp_pkg::ST_OK) begin
          qt = {msg_mem[off], msg_mem[off+1]};
          qc = {msg_mem[off+2], msg_mem[off+3]};
        end
      end
    end
    if (st != dqp_pkg::ST_OK) nl = 0;
    for (pos = 0; pos < nl; pos += 8) begin
      r = '0;
      n = (nl - pos > 8) ? 8 : nl - pos;
      for (int k = 0; k < n; k++) r.chunk[8*k +: 8] = nm[pos + k];
      r.nbytes = n;
      expected_q.push_back(r);
    end
    r = '0;
    r.status = st;
    r.id = hd[0]; r.flags = hd[1]; r.qdc = hd[2];
    r.anc = hd[3]; r.nsc = hd[4]; r.arc = hd[5];
    r.qtype = qt; r.qclass = qc; r.last = 1'b1;
    expected_q.push_back(r);
    msg_len = 0;
    msg_over = 0;
  endtask

  // one word to the block, predictor updated on acceptance
  task automatic send_word(input logic [7:0] b, input logic lastb);
    while (idle_on && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; in_msg_byte <= b; in_last_byte <= lastb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (msg_len < MSG_MAX) msg_mem[msg_len++] = b;
    else msg_over = 1;
    if (lastb) predict_message();
    @(negedge clk);
  endtask

  task automatic send_msg(input byte unsigned m[$]);
    foreach (m[i]) send_word(m[i], i == m.size() - 1);
  endtask

  // header with random fields, question count qd
  function automatic void put_hdr(ref byte unsigned m[$], input logic [15:0] qd);
    logic [15:0] w[6];
    m.delete();
    w[0] = $urandom; w[1] = $urandom; w[2] = qd;
    w[3] = $urandom; w[4] = $urandom; w[5] = $urandom;
    foreach (w[k]) begin m.push_back(w[k][15:8]); m.push_back(w[k][7:0]); end
  endfunction

  function automatic void put_label(ref byte unsigned m[$], input int len);
    m.push_back(len);
    repeat (len) m.push_back($urandom_range(33, 126));
  endfunction

  function automatic void put_tail(ref byte unsigned m[$]);
    repeat (4) m.push_back($urandom);
  endfunction

  // random, mostly well-formed message
  task automatic send_random();
    byte unsigned m[$];
    int nlab, kind, p;
    int offs[$];
    kind = $urandom_range(99);
    put_hdr(m, ($urandom_range(9) == 0) ? 16'h0 : $urandom_range(1, 3));
    if (kind < 5) begin
      repeat ($urandom_range(11)) m.push_back($urandom);
      m.delete(m.size() - 1 < 0 ? 0 : m.size() - 1);
      m = m[0:$urandom_range(10)];
    end else begin
      nlab = $urandom_range(0, 5);
      repeat (nlab) begin
        offs.push_back(m.size());
        put_label(m, ($urandom_range(9) == 0) ? 63 : $urandom_range(1, 12));
      end
      if (kind < 25 && offs.size() > 0) begin
        p = (kind < 20) ? offs[$urandom_range(offs.size() - 1)] : $urandom_range(16383);
        m.push_back(8'hc0 | p[13:8]); m.push_back(p[7:0]);
      end else if (kind < 30) begin
        m.push_back($urandom_range(64, 191));
      end else m.push_back(0);
      if (kind < 90) put_tail(m);
      else repeat ($urandom_range(3)) m.push_back($urandom);
      if (kind >= 95) repeat ($urandom_range(1, 20)) m.push_back($urandom);
    end
    send_msg(m);
  endtask

  // checker
  always @(posedge clk) begin
    rec_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_name_chunk, out_chunk_bytes, out_status, out_msg_id, out_flag_bits,
              out_question_count, out_answer_count, out_authority_count,
              out_additional_count, out_query_type, out_query_class, out_last};
      if (expected_q.size() == 0) report("unexpected word", got.chunk, 0);
      else begin
        want = expected_q.pop_front();
        if (got.chunk !== want.chunk) report("name_chunk", got.chunk, want.chunk);
        if (got.nbytes !== want.nbytes) report("chunk_bytes", got.nbytes, want.nbytes);
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.id !== want.id) report("msg_id", got.id, want.id);
        if (got.flags !== want.flags) report("flag_bits", got.flags, want.flags);
        if (got.qdc !== want.qdc) report("question_count", got.qdc, want.qdc);
        if (got.anc !== want.anc) report("answer_count", got.anc, want.anc);
        if (got.nsc !== want.nsc) report("authority_count", got.nsc, want.nsc);
        if (got.arc !== want.arc) report("additional_count", got.arc, want.arc);
        if (got.qtype !== want.qtype) report("query_type", got.qtype, want.qtype);
        if (got.qclass !== want.qclass) report("query_class", got.qclass, want.qclass);
        if (got.last !== want.last) report("last", got.last, want.last);
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (!rst_n || hold_out) out_stall <= 1'b1;
    else out_stall <= idle_on && ($urandom_range(99) < 36);
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_CAP) begin
      $display("FAIL dns_question_parser");
      $finish;
    end
  end

  typedef struct {
    int    kind;       // what the row builds
    bit    chk;        // summary typed in
    logic [1:0] st;
  } row_t;
  localparam int R_SHORT = 0, R_ZEROQ = 1, R_WWW = 2, R_PTR = 3, R_BADPTR = 4,
                 R_BADLAB = 5, R_PASTEND = 6, R_SHORTQ = 7, R_LONG = 8,
                 R_POOL = 9, R_OVER = 10, R_MAXB = 11, R_CHAIN = 12;

  initial begin
    row_t rows[$];
    byte unsigned m[$];
    rec_t ex;
    rows = '{'{R_SHORT, 1, dqp_pkg::ST_BADLEN}, '{R_ZEROQ, 1, dqp_pkg::ST_OK},
             '{R_WWW, 0, dqp_pkg::ST_OK}, '{R_PTR, 0, dqp_pkg::ST_OK},
             '{R_BADPTR, 1, dqp_pkg::ST_MALFORMED},
             '{R_BADLAB, 1, dqp_pkg::ST_MALFORMED},
             '{R_PASTEND, 1, dqp_pkg::ST_MALFORMED},
             '{R_SHORTQ, 1, dqp_pkg::ST_MALFORMED},
             '{R_LONG, 1, dqp_pkg::ST_MALFORMED},
             '{R_POOL, 1, dqp_pkg::ST_POOLFULL}, '{R_OVER, 1, dqp_pkg::ST_BADLEN},
             '{R_MAXB, 0, dqp_pkg::ST_OK}, '{R_CHAIN, 0, dqp_pkg::ST_OK}};
    msg_len = 0; msg_over = 0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    foreach (rows[i]) begin
      put_hdr(m, 1);
      case (rows[i].kind)
        R_SHORT:   m = m[0:10];
        R_ZEROQ:   begin m[4] = 0; m[5] = 0; end
        R_WWW:     begin put_label(m, 3); put_label(m, 7); put_label(m, 3);
                         m.push_back(0); put_tail(m); end
        R_PTR:     begin put_label(m, 63); m.push_back(8'hc0); m.push_back(12);
                         put_tail(m); end
        R_BADPTR:  begin put_label(m, 2); m.push_back(8'hff); m.push_back(8'hff);
                         put_tail(m); end
        R_BADLAB:  begin m.push_back(64); put_tail(m); end
        R_PASTEND: put_label(m, 5);
        R_SHORTQ:  begin put_label(m, 1); m.push_back(0); m.push_back(1); end
        R_LONG:    begin repeat (5) put_label(m, 63); m.push_back(0); put_tail(m); end
        R_POOL:    begin repeat (128) put_label(m, 0 + 1); m.push_back(0); put_tail(m); end
        R_OVER:    repeat (MSG_MAX + 1 - 12) m.push_back($urandom);
        R_MAXB:    begin m[0] = 8'hff; m[1] = 8'hff; m[2] = 8'hff; m[3] = 8'hff;
                         m[4] = 8'hff; m[5] = 8'hff; put_label(m, 1); m.push_back(0);
                         repeat (4) m.push_back(8'hff); end
        R_CHAIN:   begin put_label(m, 2); put_label(m, 4); m.push_back(8'hc0);
                         m.push_back(15); put_tail(m); end
      endcase
      send_msg(m);
      if (rows[i].chk) begin
        ex = expected_q[$];
        if (ex.status !== rows[i].st) report("table status", ex.status, rows[i].st);
      end
    end
    // no idling for a while
    idle_on = 0;
    repeat (40) send_random();
    idle_on = 1;
    // long receiver hold while messages keep coming
    fork
      begin hold_out = 1; repeat (400) @(negedge clk); hold_out = 0; end
      repeat (6) send_random();
    join
    repeat (104) send_random();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("PASS dns_question_parser");
    else $display("FAIL dns_question_parser");
    $finish;
  end
endmodule
